>>> sv/dlq_pkg.sv
// ============================================================================
// dlq_pkg - shared types and constants of the device lock wait queue
// Sizes, status codes, operation codes and the controller command word.
// ============================================================================
package dlq_pkg;

    // Sizing
    localparam int NUM_DEVICES = 3;
    localparam int QUEUE_DEPTH = 8;

    localparam int DEV_W     = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int DEV_SLOTS = 2 ** DEV_W;
    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = DEV_SLOTS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // Word field widths
    localparam int DEVICE_W = 3;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;
    localparam int WAIT_W   = 4;

    localparam logic [DEVICE_W:0] DEV_LIMIT = (DEVICE_W + 1)'(NUM_DEVICES);

    // Operation codes
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED      = 3'd0,
        ST_QUEUED       = 3'd1,
        ST_FULL         = 3'd2,
        ST_HANDED       = 3'd3,
        ST_FREED        = 3'd4,
        ST_ALREADY_FREE = 3'd5,
        ST_BAD_DEVICE   = 3'd6
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the word and read the queue head
        logic execute;   // update device state and load the result
    } t_dp_cmd;

    // Advance a ring pointer
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

>>> sv/dlq_if.sv
// ============================================================================
// dlq_in_if / dlq_out_if - valid/ready channels of the device lock block
// Request words go in on dlq_in_if, result words come out on dlq_out_if.
// ============================================================================
interface dlq_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [dlq_pkg::DEVICE_W-1:0] device;
    logic [dlq_pkg::ID_W-1:0]     requester;

    modport source (output valid, mode, device, requester, input ready);
    modport sink   (input valid, mode, device, requester, output ready);
endinterface

interface dlq_out_if;
    logic                        valid;
    logic                        ready;
    logic [dlq_pkg::STATUS_W-1:0] status;
    logic                        busy_res;
    logic [dlq_pkg::ID_W-1:0]     owner;
    logic [dlq_pkg::ID_W-1:0]     released_owner;
    logic [dlq_pkg::WAIT_W-1:0]   waiting;

    modport source (output valid, status, busy_res, owner, released_owner, waiting,
                    input ready);
    modport sink   (input valid, status, busy_res, owner, released_owner, waiting,
                    output ready);
endinterface

>>> sv/dlq_ctrl.sv
// ============================================================================
// dlq_ctrl - sequencer of the device lock block
// Takes one word, runs it through the datapath, holds the result valid flag.
// ============================================================================
module dlq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output dlq_pkg::t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // Result slot can take a new word when empty or draining now
    assign out_free = !r_out_valid || i_out_ready;

    // Decode commands from state
    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.execute = (r_state == S_EXEC) && out_free;
    end

    // Next state and result flag
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the registered valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten while still pending");

    // Every executed word shows up as a result next cycle
    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |=> r_out_valid)
        else $error("executed word produced no result");

    // A captured word is executed before the next one is taken
    a_capture_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> !o_cmd.capture)
        else $error("second word captured before execution");

endmodule

>>> sv/dlq_datapath.sv
// ============================================================================
// dlq_datapath - device state, wait queues and result register
// Keeps busy flags, owners, ring pointers and counts per device, and the
// shared queue memory of waiting requester IDs.
// ============================================================================
module dlq_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dlq_pkg::t_dp_cmd             i_cmd,
    input  logic                         i_mode,
    input  logic [dlq_pkg::DEVICE_W-1:0] i_device,
    input  logic [dlq_pkg::ID_W-1:0]     i_requester,
    output logic [dlq_pkg::STATUS_W-1:0] o_status,
    output logic                         o_busy_res,
    output logic [dlq_pkg::ID_W-1:0]     o_owner,
    output logic [dlq_pkg::ID_W-1:0]     o_released_owner,
    output logic [dlq_pkg::WAIT_W-1:0]   o_waiting
);

    // Per-device state
    logic                        r_busy  [dlq_pkg::DEV_SLOTS];
    logic [dlq_pkg::ID_W-1:0]    r_owner [dlq_pkg::DEV_SLOTS];
    logic [dlq_pkg::PTR_W-1:0]   r_head  [dlq_pkg::DEV_SLOTS];
    logic [dlq_pkg::PTR_W-1:0]   r_tail  [dlq_pkg::DEV_SLOTS];
    logic [dlq_pkg::CNT_W-1:0]   r_cnt   [dlq_pkg::DEV_SLOTS];

    // Queue memory
    logic [dlq_pkg::ID_W-1:0]    r_mem   [dlq_pkg::MEM_DEPTH];
    logic [dlq_pkg::ID_W-1:0]    r_rd_data;

    // Captured word
    logic                        r_mode;
    logic                        r_dev_ok;
    logic [dlq_pkg::DEV_W-1:0]   r_dev;
    logic [dlq_pkg::ID_W-1:0]    r_req;

    // Result register
    dlq_pkg::t_status            r_o_status;
    logic                        r_o_busy;
    logic [dlq_pkg::ID_W-1:0]    r_o_owner;
    logic [dlq_pkg::ID_W-1:0]    r_o_rel;
    logic [dlq_pkg::WAIT_W-1:0]  r_o_wait;

    logic [dlq_pkg::DEV_W-1:0]   in_dev;
    logic                        in_dev_ok;
    logic [dlq_pkg::ADDR_W-1:0]  rd_addr;
    logic [dlq_pkg::ADDR_W-1:0]  wr_addr;

    logic                        cur_busy;
    logic [dlq_pkg::ID_W-1:0]    cur_owner;
    logic [dlq_pkg::PTR_W-1:0]   cur_head;
    logic [dlq_pkg::PTR_W-1:0]   cur_tail;
    logic [dlq_pkg::CNT_W-1:0]   cur_cnt;

    logic                        n_busy;
    logic [dlq_pkg::ID_W-1:0]    n_owner;
    logic [dlq_pkg::PTR_W-1:0]   n_head;
    logic [dlq_pkg::PTR_W-1:0]   n_tail;
    logic [dlq_pkg::CNT_W-1:0]   n_cnt;
    logic                        wr_en;
    dlq_pkg::t_status            n_status;
    logic [dlq_pkg::ID_W-1:0]    n_rel;

    // Decode the incoming device and its queue head address
    assign in_dev    = i_device[dlq_pkg::DEV_W-1:0];
    assign in_dev_ok = ({1'b0, i_device} < dlq_pkg::DEV_LIMIT);
    assign rd_addr   = dlq_pkg::ADDR_W'(in_dev) * dlq_pkg::ADDR_W'(dlq_pkg::QUEUE_DEPTH)
                     + dlq_pkg::ADDR_W'(r_head[in_dev]);
    assign wr_addr   = dlq_pkg::ADDR_W'(r_dev) * dlq_pkg::ADDR_W'(dlq_pkg::QUEUE_DEPTH)
                     + dlq_pkg::ADDR_W'(cur_tail);

    // Select the captured device's state
    assign cur_busy  = r_busy[r_dev];
    assign cur_owner = r_owner[r_dev];
    assign cur_head  = r_head[r_dev];
    assign cur_tail  = r_tail[r_dev];
    assign cur_cnt   = r_cnt[r_dev];

    // Apply the request or release to one device
    always_comb begin
        n_busy   = cur_busy;
        n_owner  = cur_owner;
        n_head   = cur_head;
        n_tail   = cur_tail;
        n_cnt    = cur_cnt;
        wr_en    = 1'b0;
        n_rel    = '0;
        n_status = dlq_pkg::ST_BAD_DEVICE;
        if (!r_dev_ok) begin
            n_status = dlq_pkg::ST_BAD_DEVICE;
        end else if (r_mode == dlq_pkg::MODE_REQUEST) begin
            if (!cur_busy) begin
                n_busy   = 1'b1;
                n_owner  = r_req;
                n_status = dlq_pkg::ST_GRANTED;
            end else if (cur_cnt >= dlq_pkg::CNT_W'(dlq_pkg::QUEUE_DEPTH)) begin
                n_status = dlq_pkg::ST_FULL;
            end else begin
                wr_en    = 1'b1;
                n_tail   = dlq_pkg::ring_next(cur_tail);
                n_cnt    = cur_cnt + 1'b1;
                n_status = dlq_pkg::ST_QUEUED;
            end
        end else begin
            if (!cur_busy) begin
                n_status = dlq_pkg::ST_ALREADY_FREE;
            end else begin
                n_rel = cur_owner;
                if (cur_cnt != '0) begin
                    n_owner  = r_rd_data;
                    n_head   = dlq_pkg::ring_next(cur_head);
                    n_cnt    = cur_cnt - 1'b1;
                    n_status = dlq_pkg::ST_HANDED;
                end else begin
                    n_busy   = 1'b0;
                    n_owner  = '0;
                    n_status = dlq_pkg::ST_FREED;
                end
            end
        end
    end

    // Hold per-device control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dlq_pkg::DEV_SLOTS; i++) begin
                r_busy[i]  <= 1'b0;
                r_owner[i] <= '0;
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_cnt[i]   <= '0;
            end
        end else if (i_cmd.execute && r_dev_ok) begin
            r_busy[r_dev]  <= n_busy;
            r_owner[r_dev] <= n_owner;
            r_head[r_dev]  <= n_head;
            r_tail[r_dev]  <= n_tail;
            r_cnt[r_dev]   <= n_cnt;
        end
    end

    // Queue memory: write on enqueue, read head on capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && wr_en) begin
            r_mem[wr_addr] <= r_req;
        end
        if (i_cmd.capture) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Latch the word and load the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode   <= i_mode;
            r_dev    <= in_dev;
            r_dev_ok <= in_dev_ok;
            r_req    <= i_requester;
        end
        if (i_cmd.execute) begin
            r_o_status <= n_status;
            r_o_busy   <= r_dev_ok && n_busy;
            r_o_owner  <= (r_dev_ok && n_busy) ? n_owner : '0;
            r_o_rel    <= n_rel;
            r_o_wait   <= r_dev_ok ? dlq_pkg::WAIT_W'(n_cnt) : '0;
        end
    end

    assign o_status         = r_o_status;
    assign o_busy_res       = r_o_busy;
    assign o_owner          = r_o_owner;
    assign o_released_owner = r_o_rel;
    assign o_waiting        = r_o_wait;

    // Queue count stays within depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute && r_dev_ok |-> cur_cnt <= dlq_pkg::CNT_W'(dlq_pkg::QUEUE_DEPTH))
        else $error("wait count above queue depth");

    // A free device has nobody waiting
    a_free_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute && r_dev_ok && !cur_busy |-> cur_cnt == '0)
        else $error("free device with waiting entries");

    // Head, count and tail agree on an empty queue
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute && r_dev_ok && cur_cnt == '0 |-> cur_head == cur_tail)
        else $error("empty queue with head and tail apart");

endmodule

>>> sv/device_lock_fifo_wait_queue.sv
// ============================================================================
// device_lock_fifo_wait_queue - exclusive device lock with FIFO wait queues
// Grants, queues and hands over ownership of a few devices.
// ============================================================================
// Usage:
//   i_in carries one word per operation: mode (request or release), device
//   index and requester ID. o_out returns one result word per input word:
//   status, busy flag, owner, released owner and queue fill of the device.
//   Both channels move a word when valid and ready are high at a clock edge.
//   The sequencer captures the word and reads the queue head from memory in
//   its capture step, then updates the device state and loads the result
//   register in its execute step. i_in is ready only in the idle state, so a
//   new word is not taken until the previous one has been executed.
//   The result register parts the channels: a new word is taken while the
//   previous result still waits. If o_out stalls, the next word is held in
//   the update step until the result register frees up.
//   Reset (i_rst_n low, synchronous) frees all devices and empties all queues.
//   The queue memory needs no clearing; entries are read only once written.
// ============================================================================
module device_lock_fifo_wait_queue (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dlq_in_if.sink    i_in,
    dlq_out_if.source o_out
);

    dlq_pkg::t_dp_cmd cmd;
    logic             in_ready;
    logic             out_valid;

    // Sequencer
    dlq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    // Device state and queues
    dlq_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_mode           (i_in.mode),
        .i_device         (i_in.device),
        .i_requester      (i_in.requester),
        .o_status         (o_out.status),
        .o_busy_res       (o_out.busy_res),
        .o_owner          (o_out.owner),
        .o_released_owner (o_out.released_owner),
        .o_waiting        (o_out.waiting)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule
